// ===== hw/rtl/bdsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants for the button debounce / press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsl_pkg;

    // Configuration port widths
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register width of the length registers
    localparam int unsigned LEN_W = 16;

    // Stream payload widths (padded to whole bytes)
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STABLE_LENGTH     = 2'd0,
        REG_LONG_PRESS_LENGTH = 2'd1,
        REG_HOLD_MODE         = 2'd2
    } t_reg_index;

    // Event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_event;

endpackage

`default_nettype wire

// ===== hw/rtl/button_debounce_short_long_press.sv =====
// The result of an input transfer is registered and appears on the master side in the cycle after the transfer.
// Throughput: one sample per cycle while the master side takes each result; the output
// register frees up in the same cycle its result is taken, so a new sample is accepted alongside it.
// Reset (i_rst_n low, synchronous): config returns to stable length 1, long
// press length 0, edge mode; debounce state clears, armed flag set, no output.
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// Debounces one raw button sample per transfer and reports press-edge, short
// press and long press events together with the debounced level.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_short_long_press #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bdsl_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [bdsl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample input
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: [0] raw_level, [7:1] zero
    input  wire logic [bdsl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result output
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: [1:0] event_code, [2] debounced_level, [7:3] zero
    output logic [bdsl_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    // Compare width covers both the counters and the 16-bit registers
    localparam int unsigned EW = (COUNT_WIDTH > bdsl_pkg::LEN_W) ?
                                 COUNT_WIDTH : bdsl_pkg::LEN_W;
    localparam logic [EW-1:0] CntMax = EW'((64'd1 << COUNT_WIDTH) - 64'd1);

    // Configuration registers
    logic [bdsl_pkg::LEN_W-1:0] r_stable_length;
    logic [bdsl_pkg::LEN_W-1:0] r_long_press_length;
    logic                       r_hold_mode;

    // Debounce state
    logic                   r_prev_raw,  n_prev_raw;
    logic [COUNT_WIDTH-1:0] r_run,       n_run;
    logic                   r_level,     n_level;
    logic                   r_armed,     n_armed;
    logic [COUNT_WIDTH-1:0] r_hold,      n_hold;
    logic                   r_long_done, n_long_done;

    // Output register
    logic                   r_out_valid;
    logic [1:0]             r_out_event;
    logic                   r_out_level;
    bdsl_pkg::t_event       n_event;

    logic                   in_xfer;
    logic                   raw;
    logic [EW-1:0]          need_ext;
    logic [EW-1:0]          thr_ext;
    logic [COUNT_WIDTH-1:0] need;
    logic [COUNT_WIDTH-1:0] thresh;
    logic                   stable;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[0];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(bdsl_pkg::OUT_TDATA_W-3){1'b0}}, r_out_level, r_out_event};

    // Effective stable length and long-press threshold, clamped to counter range
    always_comb begin
        need_ext = EW'(r_stable_length);
        if (need_ext == '0) begin
            need_ext = EW'(1);
        end
        if (need_ext > CntMax) begin
            need_ext = CntMax;
        end
        thr_ext = EW'(r_long_press_length);
        if (need_ext > thr_ext) begin
            thr_ext = need_ext;
        end
        if (thr_ext > CntMax) begin
            thr_ext = CntMax;
        end
        need   = need_ext[COUNT_WIDTH-1:0];
        thresh = thr_ext[COUNT_WIDTH-1:0];
    end

    // Next state and event for the sample on the input
    always_comb begin
        n_prev_raw  = raw;
        n_level     = r_level;
        n_armed     = r_armed;
        n_hold      = r_hold;
        n_long_done = r_long_done;
        n_event     = bdsl_pkg::EV_NONE;

        // raw run tracking
        if (raw == r_prev_raw) begin
            n_run = (r_run < need) ? r_run + 1'b1 : r_run;
        end else begin
            n_run = COUNT_WIDTH'(1);
        end
        stable = (n_run >= need);

        if (stable) begin
            if (!r_hold_mode) begin
                // edge mode
                if (r_level != raw) begin
                    n_level = raw;
                    if (!raw) begin
                        n_armed = 1'b1;
                    end else if (r_armed) begin
                        n_armed = 1'b0;
                        n_event = bdsl_pkg::EV_PRESS;
                    end
                end
            end else if ((r_level != raw) && !raw) begin
                // hold mode, release accepted
                n_level     = 1'b0;
                n_hold      = '0;
                n_long_done = 1'b0;
                n_armed     = 1'b1;
                if (r_armed && !r_long_done) begin
                    n_event = bdsl_pkg::EV_SHORT;
                end
            end else begin
                // hold mode, press accepted or level unchanged
                if (r_level != raw) begin
                    n_level     = 1'b1;
                    n_hold      = n_run;
                    n_long_done = 1'b0;
                end else if (raw && (r_hold != CntMax[COUNT_WIDTH-1:0])) begin
                    n_hold = r_hold + 1'b1;
                end
                if (raw && r_armed && !n_long_done && (n_hold >= thresh)) begin
                    n_long_done = 1'b1;
                    n_armed     = 1'b0;
                    n_event     = bdsl_pkg::EV_LONG;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_length     <= bdsl_pkg::LEN_W'(1);
            r_long_press_length <= '0;
            r_hold_mode         <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdsl_pkg::REG_STABLE_LENGTH:     r_stable_length     <= i_cfg_data;
                bdsl_pkg::REG_LONG_PRESS_LENGTH: r_long_press_length <= i_cfg_data;
                bdsl_pkg::REG_HOLD_MODE:         r_hold_mode         <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Debounce state, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= 1'b0;
            r_run       <= '0;
            r_level     <= 1'b0;
            r_armed     <= 1'b1;
            r_hold      <= '0;
            r_long_done <= 1'b0;
        end else if (in_xfer) begin
            r_prev_raw  <= n_prev_raw;
            r_run       <= n_run;
            r_level     <= n_level;
            r_armed     <= n_armed;
            r_hold      <= n_hold;
            r_long_done <= n_long_done;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_event <= n_event;
            r_out_level <= n_level;
        end
    end

endmodule

`default_nettype wire
